// ===== hdl/pcd_pkg.sv =====
// Package for the pushbuffer command decoder.
// Holds the error codes, register indexes and decode masks; no dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned MethodW  = 14;
  localparam int unsigned SubchW   = 3;
  localparam int unsigned CountW   = 11;
  localparam int unsigned ErrW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutDataW = 104;

  localparam logic [ErrW-1:0] ERR_NONE       = 3'd0;
  localparam logic [ErrW-1:0] ERR_PROTECTION = 3'd1;
  localparam logic [ErrW-1:0] ERR_CALL       = 3'd2;
  localparam logic [ErrW-1:0] ERR_RETURN     = 3'd3;
  localparam logic [ErrW-1:0] ERR_RESERVED   = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_BUFFER_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PUT_ADDRESS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GET_START    = 2'd2;

  localparam logic [WordW-1:0] OLD_JUMP_MASK  = 32'he000_0003;
  localparam logic [WordW-1:0] OLD_JUMP_CODE  = 32'h2000_0000;
  localparam logic [WordW-1:0] OLD_JUMP_ADDR  = 32'h1fff_ffff;
  localparam logic [WordW-1:0] ALIGN_MASK     = 32'hffff_fffc;
  localparam logic [WordW-1:0] RETURN_WORD    = 32'h0002_0000;
  localparam logic [WordW-1:0] HEADER_MASK    = 32'he003_0003;
  localparam logic [WordW-1:0] HEADER_INC     = 32'h0000_0000;
  localparam logic [WordW-1:0] HEADER_NONINC  = 32'h4000_0000;
  localparam logic [1:0]       CMD_JUMP       = 2'd1;
  localparam logic [1:0]       CMD_CALL       = 2'd2;

endpackage

// ===== hdl/pushbuffer_command_decoder.sv =====
// Pushbuffer command decoder: decodes FIFO command words into method items.
// Depends on pcd_pkg.
// A result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; the decode state updates in the accept cycle
// and the result sits in an output register, so input is taken whenever that
// register is empty or being drained.
// Reset (rst_ni low, asynchronous) clears all decoder state and the valid flag.
`timescale 1ns / 1ps

module pushbuffer_command_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [pcd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pcd_pkg::WordW-1:0]         cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: word[31:0].
  input  logic [pcd_pkg::WordW-1:0]         s_axis_tdata,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: method_address[13:0], subchannel[16:14],
  // nonincreasing[17], parameter_res[49:18], next_get[81:50],
  // error_code[84:82], caught_up[85], data_count[96:86], zero fill.
  output logic [pcd_pkg::OutDataW-1:0]      m_axis_tdata,
  // Fields from bit 0: command_valid[0].
  output logic                              m_axis_tuser
);

  localparam int unsigned WordW   = pcd_pkg::WordW;
  localparam int unsigned MethodW = pcd_pkg::MethodW;
  localparam int unsigned SubchW  = pcd_pkg::SubchW;
  localparam int unsigned CountW  = pcd_pkg::CountW;
  localparam int unsigned ErrW    = pcd_pkg::ErrW;

  logic [WordW-1:0]   limit_q, put_q;
  logic [WordW-1:0]   get_q, get_d;
  logic [MethodW-1:0] method_q, method_d;
  logic [SubchW-1:0]  sub_q, sub_d;
  logic [CountW-1:0]  remain_q, remain_d;
  logic               hold_q, hold_d;
  logic               call_q, call_d;
  logic [WordW-1:0]   ret_q, ret_d;
  logic [CountW-1:0]  issued_q, issued_d;
  logic [ErrW-1:0]    err_q, err_d;

  logic               cmd_valid;
  logic [MethodW-1:0] cmd_addr;
  logic [SubchW-1:0]  cmd_sub;
  logic               cmd_hold;
  logic [WordW-1:0]   cmd_par;

  logic               out_valid_q;
  logic               out_user_q;
  logic [pcd_pkg::OutDataW-1:0] out_data_q;

  logic               accept;
  logic [WordW-1:0]   w;
  logic [WordW-1:0]   get_plus;

  assign w        = s_axis_tdata;
  assign get_plus = get_q + WordW'(4);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    get_d     = get_q;
    method_d  = method_q;
    sub_d     = sub_q;
    remain_d  = remain_q;
    hold_d    = hold_q;
    call_d    = call_q;
    ret_d     = ret_q;
    issued_d  = issued_q;
    err_d     = err_q;
    cmd_valid = 1'b0;
    cmd_addr  = '0;
    cmd_sub   = '0;
    cmd_hold  = 1'b0;
    cmd_par   = '0;
    if (err_q == pcd_pkg::ERR_NONE && get_q != put_q) begin
      if (get_q >= limit_q) begin
        err_d = pcd_pkg::ERR_PROTECTION;
      end else begin
        get_d = get_plus;
        if (remain_q != '0) begin
          cmd_valid = 1'b1;
          cmd_addr  = method_q;
          cmd_sub   = sub_q;
          cmd_hold  = hold_q;
          cmd_par   = w;
          if (!hold_q) begin
            method_d = method_q + MethodW'(4);
          end
          remain_d = remain_q - CountW'(1);
          issued_d = issued_q + CountW'(1);
        end else if ((w & pcd_pkg::OLD_JUMP_MASK) == pcd_pkg::OLD_JUMP_CODE) begin
          get_d = w & pcd_pkg::OLD_JUMP_ADDR;
        end else if (w[1:0] == pcd_pkg::CMD_JUMP) begin
          get_d = w & pcd_pkg::ALIGN_MASK;
        end else if (w[1:0] == pcd_pkg::CMD_CALL) begin
          if (call_q) begin
            err_d = pcd_pkg::ERR_CALL;
          end else begin
            ret_d  = get_plus;
            call_d = 1'b1;
            get_d  = w & pcd_pkg::ALIGN_MASK;
          end
        end else if (w == pcd_pkg::RETURN_WORD) begin
          if (!call_q) begin
            err_d = pcd_pkg::ERR_RETURN;
          end else begin
            get_d  = ret_q;
            call_d = 1'b0;
          end
        end else if ((w & pcd_pkg::HEADER_MASK) == pcd_pkg::HEADER_INC ||
                     (w & pcd_pkg::HEADER_MASK) == pcd_pkg::HEADER_NONINC) begin
          method_d = {1'b0, w[12:0]};
          sub_d    = w[15:13];
          remain_d = w[28:18];
          hold_d   = w[30];
          issued_d = '0;
        end else begin
          err_d = pcd_pkg::ERR_RESERVED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= '0;
      put_q    <= '0;
      get_q    <= '0;
      method_q <= '0;
      sub_q    <= '0;
      remain_q <= '0;
      hold_q   <= 1'b0;
      call_q   <= 1'b0;
      ret_q    <= '0;
      issued_q <= '0;
      err_q    <= pcd_pkg::ERR_NONE;
    end else begin
      if (cfg_we_i && cfg_index_i == pcd_pkg::CFG_GET_START) begin
        get_q <= cfg_data_i;
        err_q <= pcd_pkg::ERR_NONE;
      end else if (accept) begin
        get_q <= get_d;
        err_q <= err_d;
      end
      if (accept) begin
        method_q <= method_d;
        sub_q    <= sub_d;
        remain_q <= remain_d;
        hold_q   <= hold_d;
        call_q   <= call_d;
        ret_q    <= ret_d;
        issued_q <= issued_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcd_pkg::CFG_BUFFER_LIMIT: limit_q <= cfg_data_i;
          pcd_pkg::CFG_PUT_ADDRESS:  put_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_user_q <= cmd_valid;
      out_data_q <= {7'd0, issued_d, (get_d == put_q), err_d, get_d,
                     cmd_par, cmd_hold, cmd_sub, cmd_addr};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== hdl/pcd_checker.sv =====
// Port-level checker for the pushbuffer command decoder, bound to the top level.
// Depends on pcd_pkg and pushbuffer_command_decoder.
`timescale 1ns / 1ps

module pcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pcd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  // A stalled result must hold its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // An empty output register always takes input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // An accepted item yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // Method commands never carry an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[84:82] == pcd_pkg::ERR_NONE)
    else $error("method command issued with an error set");

  // Non-command results carry zero method fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[49:0] == '0)
    else $error("non-command result has method fields");

endmodule

bind pushbuffer_command_decoder pcd_checker u_pcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
